// ===== rtl/core/longest_prefix_route_table_macros.svh =====
// Assertion macros for the route table RTL.
// Needs clk and rst_n in scope where a macro is used; empty when SYNTH is defined.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define LPRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lprt assertion failed");

// antecedent implies consequent in the next cycle
`define LPRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lprt assertion failed");

`else

`define LPRT_ASSERT_IMPL(lbl, ante, cons)
`define LPRT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/lprt_pkg.sv =====
// Shared types, constants and helpers for the longest prefix route table.
// No dependencies; imported by every module of the block.
package lprt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PORT_W  = 8;
  localparam int OP_W    = 2;

  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(ADDR_W);
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT,
    S_FETCH
  } lprt_state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic ld_out;
  } lprt_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lprt_sts_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
  } lprt_key_t;

  typedef struct packed {
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] cost;
  } lprt_data_t;

  // top len bits set; len of zero gives an empty mask (default route)
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~(ADDR_ONES >> len);
  endfunction

endpackage

// ===== rtl/core/longest_prefix_route_table.sv =====
// Longest prefix match IPv4 route table, top level.
// Depends on lprt_pkg, lprt_ctrl and lprt_dpath.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    op, prefix, length, port, hop, cost, addr
//   out      source     out_valid / out_stall  found, status, nexthop, egress_port, metric
//
// After acceptance, out_valid rises once these steps are done: one pass of the key memory
// read port over all slots, a compare flush, commit and data read, result load.
// The input is free again in the cycle in which out_valid rises; a new transaction waits until the last is done.
// Reset leaves every slot invalid; no clearing pass, input ready as soon as reset is released.
// A result waiting under out_stall does not block acceptance of the next transaction;
// that transaction's result waits at its last step until the result register frees.
module longest_prefix_route_table
  import lprt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ADDR_W-1:0] in_route_prefix,
  input  logic [LEN_W-1:0]  in_prefix_len,
  input  logic [PORT_W-1:0] in_route_port,
  input  logic [ADDR_W-1:0] in_route_hop,
  input  logic [ADDR_W-1:0] in_route_cost,
  input  logic [ADDR_W-1:0] in_lookup_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic              out_status,
  output logic [ADDR_W-1:0] out_nexthop,
  output logic [PORT_W-1:0] out_egress_port,
  output logic [ADDR_W-1:0] out_metric
);

  lprt_cmd_t cmd;
  lprt_sts_t sts;

  lprt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lprt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_route_prefix (in_route_prefix),
    .in_prefix_len   (in_prefix_len),
    .in_route_port   (in_route_port),
    .in_route_hop    (in_route_hop),
    .in_route_cost   (in_route_cost),
    .in_lookup_addr  (in_lookup_addr),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_nexthop     (out_nexthop),
    .out_egress_port (out_egress_port),
    .out_metric      (out_metric)
  );

endmodule

// ===== rtl/core/lprt_dpath.sv =====
// Route table datapath: key and data memories, valid bits, scan pipeline,
// match trackers and result register. Depends on lprt_pkg.
module lprt_dpath
  import lprt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lprt_cmd_t         cmd,
  output lprt_sts_t         sts,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ADDR_W-1:0] in_route_prefix,
  input  logic [LEN_W-1:0]  in_prefix_len,
  input  logic [PORT_W-1:0] in_route_port,
  input  logic [ADDR_W-1:0] in_route_hop,
  input  logic [ADDR_W-1:0] in_route_cost,
  input  logic [ADDR_W-1:0] in_lookup_addr,
  output logic              out_found,
  output logic              out_status,
  output logic [ADDR_W-1:0] out_nexthop,
  output logic [PORT_W-1:0] out_egress_port,
  output logic [ADDR_W-1:0] out_metric
);

  lprt_key_t  key_mem  [ENTRIES];
  lprt_data_t data_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // captured transaction
  logic [OP_W-1:0]   op_r;
  lprt_key_t         cap_key_r;
  lprt_data_t        cap_data_r;
  logic [ADDR_W-1:0] addr_r;

  logic [IDX_W-1:0] cnt_r;
  logic             rd_vld_r;
  logic             rd_valid_r;
  logic [IDX_W-1:0] rd_idx_r;
  lprt_key_t        rd_key_r;
  lprt_data_t       rd_data_r;

  logic             key_hit_r, free_hit_r, best_hit_r;
  logic [IDX_W-1:0] key_idx_r, free_idx_r, best_idx_r;
  logic [LEN_W-1:0] best_len_r;

  logic [LEN_W-1:0]  len_sat;
  logic [ADDR_W-1:0] cmp_mask;
  logic              key_eq, addr_hit, longer;
  logic              ins_ok;
  logic [IDX_W-1:0]  wr_idx;
  logic              res_found, res_status;

  assign len_sat = (in_prefix_len > MAX_LEN) ? MAX_LEN : in_prefix_len;

  assign sts.scan_last = (cnt_r == IDX_W'(ENTRIES - 1));

  assign cmp_mask = len_mask(rd_key_r.len);
  assign key_eq   = rd_valid_r && (rd_key_r == cap_key_r);
  assign addr_hit = rd_valid_r && (((addr_r ^ rd_key_r.prefix) & cmp_mask) == '0);
  assign longer   = !best_hit_r || (rd_key_r.len > best_len_r);

  assign ins_ok = key_hit_r || free_hit_r;
  assign wr_idx = key_hit_r ? key_idx_r : free_idx_r;

  assign res_found  = (op_r == OP_LOOKUP) && best_hit_r;
  assign res_status = (op_r == OP_INSERT) && !ins_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r            <= in_op;
      cap_key_r       <= '{prefix: in_route_prefix, len: len_sat};
      cap_data_r      <= '{hop: in_route_hop, port: in_route_port, cost: in_route_cost};
      addr_r          <= in_lookup_addr;
    end
  end

  // scan address and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.capture) begin
        cnt_r <= '0;
      end else if (cmd.scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_key_r   <= key_mem[cnt_r];
      rd_valid_r <= valid_r[cnt_r];
      rd_idx_r   <= cnt_r;
    end
  end

  // compare stage: first key match, first free slot, longest covering prefix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
      best_hit_r <= 1'b0;
    end else if (cmd.capture) begin
      key_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
      best_hit_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (key_eq && !key_hit_r) begin
        key_hit_r <= 1'b1;
        key_idx_r <= rd_idx_r;
      end
      if (!rd_valid_r && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (addr_hit && longer) begin
        best_hit_r <= 1'b1;
        best_idx_r <= rd_idx_r;
        best_len_r <= rd_key_r.len;
      end
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (op_r == OP_INSERT && ins_ok) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (op_r == OP_DELETE && key_hit_r) begin
        valid_r[key_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op_r == OP_INSERT && ins_ok) begin
      key_mem[wr_idx]  <= cap_key_r;
      data_mem[wr_idx] <= cap_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_data_r <= data_mem[best_idx_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_found       <= res_found;
      out_status      <= res_status;
      out_nexthop     <= res_found ? rd_data_r.hop  : '0;
      out_egress_port <= res_found ? rd_data_r.port : '0;
      out_metric      <= res_found ? rd_data_r.cost : '0;
    end
  end

endmodule

// ===== rtl/core/lprt_ctrl.sv =====
// Route table controller: sequences capture, scan, commit and result load,
// and owns both handshakes. Depends on lprt_pkg and the macros header.
`include "longest_prefix_route_table_macros.svh"

module lprt_ctrl
  import lprt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lprt_cmd_t cmd,
  input  lprt_sts_t sts
);

  lprt_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // result register may be reloaded when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_FLUSH;
      end
      S_FLUSH:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_FETCH;
      S_FETCH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SCAN:   cmd.scan   = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_FETCH:  cmd.ld_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.ld_out) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  `LPRT_ASSERT_NEXT(a_accept_starts_scan, state_r == S_IDLE && in_valid, state_r == S_SCAN)
  `LPRT_ASSERT_NEXT(a_scan_ends, state_r == S_SCAN && sts.scan_last, state_r == S_FLUSH)
  `LPRT_ASSERT_IMPL(a_load_into_free, cmd.ld_out, !out_valid_r || !out_stall)
  `LPRT_ASSERT_IMPL(a_result_from_fetch, $rose(out_valid_r), $past(state_r) == S_FETCH)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the longest prefix route table.
// Needs lprt_pkg and the longest_prefix_route_table RTL; keeps its own copy of the
// table, predicts every reply (or uses one written by hand) and checks it against the block.
module tb_top;
  import lprt_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;   // unused opcode, must do nothing
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam int REPLY_LATENCY  = ENTRIES + 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AFTER     = 200;
  localparam int NET_POOL       = 8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] hop;
    logic [ADDR_W-1:0] cost;
    logic [ADDR_W-1:0] addr;
  } route_req_t;

  typedef struct packed {
    logic              found;
    logic              status;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] cost;
  } route_res_t;

  typedef struct packed {
    route_req_t req;
    logic       typed;   // reply below is written out by hand
    route_res_t res;
  } dir_row_t;

  typedef enum int {MIX_TRAFFIC, FILL_TABLE, THIN_TABLE} traffic_mix_t;

  localparam route_res_t ZERO_REPLY = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = OP_LOOKUP;
  logic [ADDR_W-1:0] in_route_prefix = '0;
  logic [LEN_W-1:0]  in_prefix_len = '0;
  logic [PORT_W-1:0] in_route_port = '0;
  logic [ADDR_W-1:0] in_route_hop = '0;
  logic [ADDR_W-1:0] in_route_cost = '0;
  logic [ADDR_W-1:0] in_lookup_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_found;
  logic              out_status;
  logic [ADDR_W-1:0] out_nexthop;
  logic [PORT_W-1:0] out_egress_port;
  logic [ADDR_W-1:0] out_metric;

  longest_prefix_route_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_route_prefix (in_route_prefix),
    .in_prefix_len   (in_prefix_len),
    .in_route_port   (in_route_port),
    .in_route_hop    (in_route_hop),
    .in_route_cost   (in_route_cost),
    .in_lookup_addr  (in_lookup_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_nexthop     (out_nexthop),
    .out_egress_port (out_egress_port),
    .out_metric      (out_metric)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow routing table
  bit                rt_live [ENTRIES];
  logic [ADDR_W-1:0] rt_pfx  [ENTRIES];
  logic [LEN_W-1:0]  rt_len  [ENTRIES];
  logic [ADDR_W-1:0] rt_hop  [ENTRIES];
  logic [PORT_W-1:0] rt_port [ENTRIES];
  logic [ADDR_W-1:0] rt_cost [ENTRIES];

  route_res_t        pending_replies [$];
  logic [ADDR_W-1:0] net_pool [NET_POOL];

  logic       drv_typed = 1'b0;
  route_res_t drv_res = '0;
  bit         hold_on = 1'b0;
  int         rx_left = 0;
  int         in_count = 0;
  int         out_count = 0;
  int         mismatches = 0;
  int         n_insert = 0, n_full = 0, n_delete = 0, n_lookup = 0, n_hit = 0, n_nop = 0;

  function automatic logic [ADDR_W-1:0] net_mask(input int l);
    if (l == 0) return '0;
    return ADDR_ONES << (ADDR_W - l);
  endfunction

  function automatic int find_route(input logic [ADDR_W-1:0] p, input logic [LEN_W-1:0] l);
    int hit;
    int k;
    hit = -1;
    for (k = 0; k < ENTRIES; k++)
      if (hit < 0 && rt_live[k] && rt_pfx[k] == p && rt_len[k] == l) hit = k;
    return hit;
  endfunction

  // applies one transaction to the shadow table and returns the reply it earns
  function automatic route_res_t predict_route_reply(input route_req_t q);
    route_res_t       a;
    logic [LEN_W-1:0] l;
    int               slot;
    int               i;
    a = ZERO_REPLY;
    l = (q.len > MAX_LEN) ? MAX_LEN : q.len;
    slot = -1;
    case (q.op)
      OP_INSERT: begin
        slot = find_route(q.prefix, l);
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && !rt_live[i]) slot = i;
        if (slot < 0) begin
          a.status = ST_FULL;
        end else begin
          rt_live[slot] = 1'b1;
          rt_pfx[slot]  = q.prefix;
          rt_len[slot]  = l;
          rt_hop[slot]  = q.hop;
          rt_port[slot] = q.port;
          rt_cost[slot] = q.cost;
        end
      end
      OP_DELETE: begin
        slot = find_route(q.prefix, l);
        if (slot >= 0) rt_live[slot] = 1'b0;
      end
      OP_LOOKUP: begin
        // strict compare keeps the lowest slot on equal lengths
        for (i = 0; i < ENTRIES; i++)
          if (rt_live[i] && ((q.addr ^ rt_pfx[i]) & net_mask(rt_len[i])) == '0 &&
              (slot < 0 || rt_len[i] > rt_len[slot])) slot = i;
        if (slot >= 0) begin
          a.found = 1'b1;
          a.hop   = rt_hop[slot];
          a.port  = rt_port[slot];
          a.cost  = rt_cost[slot];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // mostly well-formed routes around a few networks, plus stray bits and odd lengths
  function automatic route_req_t draw_route_req(input traffic_mix_t mix);
    route_req_t        q;
    int                r;
    int                t_ins, t_del, t_lkp;
    int                l;
    int                s;
    int                pick;
    int                i;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] m;
    case (mix)
      MIX_TRAFFIC: begin t_ins = 35; t_del = 55; t_lkp = 95; end
      FILL_TABLE:  begin t_ins = 85; t_del = 88; t_lkp = 98; end
      default:     begin t_ins = 20; t_del = 60; t_lkp = 97; end
    endcase
    q.port = $urandom;
    q.hop  = $urandom;
    q.cost = $urandom;
    q.addr = $urandom;
    r = $urandom_range(0, 99);
    q.op = (r < t_ins) ? OP_INSERT : (r < t_del) ? OP_DELETE : (r < t_lkp) ? OP_LOOKUP : OP_NOP;
    r = $urandom_range(0, 19);
    l = (r == 0) ? 0 : (r < 4) ? 8 : (r < 7) ? 16 : (r < 10) ? 24 : (r < 13) ? 32 :
        (r == 13) ? $urandom_range(33, 63) : $urandom_range(1, 32);
    q.len = LEN_W'(l);
    base = (mix == FILL_TABLE && $urandom_range(0, 1) == 1) ? $urandom
                                                             : net_pool[$urandom_range(0, NET_POOL-1)];
    q.prefix = ($urandom_range(0, 9) == 0) ? $urandom : (base & net_mask(l > ADDR_W ? ADDR_W : l));
    s = $urandom_range(0, ENTRIES-1);
    pick = -1;
    for (i = 0; i < ENTRIES; i++)
      if (pick < 0 && rt_live[(s + i) % ENTRIES]) pick = (s + i) % ENTRIES;
    if (pick >= 0 && ((q.op == OP_INSERT && $urandom_range(0, 3) == 0) ||
                      (q.op == OP_DELETE && $urandom_range(0, 9) < 7))) begin
      q.prefix = rt_pfx[pick];
      q.len    = rt_len[pick];
    end
    if (q.op == OP_LOOKUP) begin
      r = $urandom_range(0, 9);
      if (r < 6 && pick >= 0) begin
        m = net_mask(rt_len[pick]);
        q.addr = (rt_pfx[pick] & m) | (q.addr & ~m);
      end else if (r < 8) begin
        m = net_mask($urandom_range(0, ADDR_W));
        q.addr = (base & m) | (q.addr & ~m);
      end
    end
    return q;
  endfunction

  function automatic route_req_t mk_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] pfx,
                                        input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port,
                                        input logic [ADDR_W-1:0] hop, input logic [ADDR_W-1:0] cost,
                                        input logic [ADDR_W-1:0] addr);
    return '{op, pfx, len, port, hop, cost, addr};
  endfunction

  function automatic route_res_t mk_res(input logic found, input logic status,
                                        input logic [ADDR_W-1:0] hop, input logic [PORT_W-1:0] port,
                                        input logic [ADDR_W-1:0] cost);
    return '{found, status, hop, port, cost};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_txn(input route_req_t q, input logic typed, input route_res_t want);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 88) ? $urandom_range(1, 3) : (r < 97) ? $urandom_range(4, 20)
                                                                     : $urandom_range(30, 90);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op           <= q.op;
    in_route_prefix <= q.prefix;
    in_prefix_len   <= q.len;
    in_route_port   <= q.port;
    in_route_hop    <= q.hop;
    in_route_cost   <= q.cost;
    in_lookup_addr  <= q.addr;
    drv_typed       <= typed;
    drv_res         <= want;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic run_phase(input traffic_mix_t mix, input int count);
    int i;
    for (i = 0; i < NET_POOL; i++) net_pool[i] = $urandom;
    for (i = 0; i < count; i++) send_txn(draw_route_req(mix), 1'b0, ZERO_REPLY);
    wait_drain();
  endtask

  always @(posedge clk) begin : capture_request
    route_req_t q;
    route_res_t p;
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      q = '{in_op, in_route_prefix, in_prefix_len, in_route_port, in_route_hop,
            in_route_cost, in_lookup_addr};
      p = predict_route_reply(q);
      pending_replies.insert(pending_replies.size(), drv_typed ? drv_res : p);
      in_count++;
      case (q.op)
        OP_INSERT: begin n_insert++; if (p.status == ST_FULL) n_full++; end
        OP_DELETE: n_delete++;
        OP_LOOKUP: begin n_lookup++; if (p.found) n_hit++; end
        default:   n_nop++;
      endcase
    end
  end

  always @(posedge clk) begin : check_reply
    route_res_t w;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      out_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d with no transaction outstanding", out_count));
      end else begin
        w = pending_replies.pop_front();
        if (out_found !== w.found)
          report_mismatch($sformatf("reply %0d found %0b, want %0b", out_count, out_found, w.found));
        if (out_status !== w.status)
          report_mismatch($sformatf("reply %0d status %0b, want %0b", out_count, out_status,
                                    w.status));
        if (out_nexthop !== w.hop)
          report_mismatch($sformatf("reply %0d nexthop %h, want %h", out_count, out_nexthop, w.hop));
        if (out_egress_port !== w.port)
          report_mismatch($sformatf("reply %0d egress port %h, want %h", out_count,
                                    out_egress_port, w.port));
        if (out_metric !== w.cost)
          report_mismatch($sformatf("reply %0d metric %h, want %h", out_count, out_metric, w.cost));
      end
    end
  end

  // receiver back-pressure: short and long stalls, plus stretches with none
  always @(negedge clk) begin : drive_stall
    int r;
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(1, 30);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(1, 4);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(50, 200);
      end else begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(20, 150);
      end
    end
  end

  // one long hold-off while the sender keeps offering, so the input side backs up
  initial begin : long_hold
    wait (in_count >= HOLD_AFTER);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   dir_tab [$];
    route_res_t dflt;
    int         i;
    dflt = mk_res(1'b1, ST_DONE, ADDR_ONES, 8'hFF, ADDR_ONES);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, then default route and all-ones host route at the field extremes
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, '0), 1'b1,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, ADDR_ONES), 1'b1,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_DELETE, '0, '0, '0, '0, '0, '0), 1'b1,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, '0, '0, 8'hFF, ADDR_ONES, ADDR_ONES, '0),
                                     1'b1, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h1234_5678), 1'b1,
                                     dflt});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, ADDR_ONES, MAX_LEN, '0, '0, '0, ADDR_ONES),
                                     1'b1, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, ADDR_ONES), 1'b1,
                                     mk_res(1'b1, ST_DONE, '0, '0, '0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'hFFFF_FFFE), 1'b1,
                                     dflt});
    // length saturation and replace in place
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, 32'h0A00_0000, 6'd63, 8'd1, 32'h0A00_0001,
                                            32'd5, '0), 1'b0, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h0A00_0000), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, 32'h0A00_0000, 6'd32, 8'd2, 32'h0A00_0002,
                                            32'd6, '0), 1'b0, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h0A00_0000), 1'b0,
                                     ZERO_REPLY});
    // stray prefix bits as distinct keys, equal lengths resolved by slot order
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, 32'hC0A8_0155, 6'd24, 8'd3, 32'hC0A8_01FE,
                                            32'd10, '0), 1'b0, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, 32'hC0A8_01AA, 6'd24, 8'd4, 32'hC0A8_01FD,
                                            32'd20, '0), 1'b0, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'hC0A8_0107), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_DELETE, 32'hC0A8_0100, 6'd24, '0, '0, '0, '0), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_DELETE, 32'hC0A8_0155, 6'd24, '0, '0, '0, '0), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'hC0A8_0107), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_NOP, ADDR_ONES, 6'h3F, 8'hFF, ADDR_ONES, ADDR_ONES,
                                            ADDR_ONES), 1'b1, ZERO_REPLY});
    // one-bit route reuses the freed slot and beats the default route
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_INSERT, 32'h8000_0000, 6'd1, 8'd7, 32'h0102_0304,
                                            32'd1, '0), 1'b0, ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h8000_0001), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_DELETE, ADDR_ONES, 6'd40, '0, '0, '0, '0), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, ADDR_ONES), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_DELETE, '0, '0, '0, '0, '0, '0), 1'b0,
                                     ZERO_REPLY});
    dir_tab.insert(dir_tab.size(), '{mk_req(OP_LOOKUP, '0, '0, '0, '0, '0, 32'h1234_5678), 1'b0,
                                     ZERO_REPLY});

    for (i = 0; i < dir_tab.size(); i++) send_txn(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    wait_drain();

    run_phase(MIX_TRAFFIC, 450);
    run_phase(FILL_TABLE, 300);
    run_phase(THIN_TABLE, 300);
    run_phase(MIX_TRAFFIC, 200);

    // catch any stray reply after the last expected one
    repeat (2 * REPLY_LATENCY) @(posedge clk);
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

    $display("covered %0d transactions: %0d inserts (%0d refused, table full), %0d deletes,",
             in_count, n_insert, n_full, n_delete);
    $display("  %0d lookups (%0d hits), %0d unused opcodes; %0d replies, %0d mismatches",
             n_lookup, n_hit, n_nop, out_count, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lprt_pkg.sv
rtl/core/lprt_dpath.sv
rtl/core/lprt_ctrl.sv
rtl/core/longest_prefix_route_table.sv
tb/tb_top.sv
